/* design/pmfb_pkg.sv */
// package for the page-organized monochrome framebuffer
// holds action and state codes, default geometry and the faint-color mask; no dependencies
`timescale 1ns / 1ps

package pmfb_pkg;

  // default geometry
  localparam int DefDisplayWidth = 128;
  localparam int DefMaxRows      = 64;

  // color channel high bits; a nonzero color without any of them is faint
  localparam logic [23:0] HighBits = 24'h808080;

  // item actions
  typedef enum logic [1:0] {
    ACT_SET_PIXEL = 2'd0,
    ACT_GET_PIXEL = 2'd1,
    ACT_CLEAR_ALL = 2'd2,
    ACT_READ_BYTE = 2'd3
  } action_e;

  // control states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RESP  = 3'b100
  } state_e;

endpackage

/* design/page_mono_framebuffer_core.sv */
// top level of the page-organized monochrome framebuffer
// one byte-wide synchronous store with read-modify-write control; uses pmfb_pkg
// set, get and read-byte: the store is read at accept, then the result is registered from S_RESP
// once the output is free; one item at a time, a new item is taken only back in S_IDLE
// clear all zeroes every byte of the store, whichever the panel height, then gives its result
// reset: control clears at once, then a clearing pass over every byte of the store
// zeroes the store while in_stall_o stays high; config writes are taken throughout
`timescale 1ns / 1ps

module page_mono_framebuffer_core
  import pmfb_pkg::*;
#(
  parameter int DISPLAY_WIDTH = DefDisplayWidth,
  parameter int MAX_ROWS      = DefMaxRows
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [6:0]  x_pos_i,
  input  logic [5:0]  y_pos_i,
  input  logic [23:0] color_i,
  input  logic [9:0]  byte_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        pixel_on_o,
  output logic [7:0]  byte_data_o,
  output logic        status_o
);

  localparam int StoreBytes = DISPLAY_WIDTH * MAX_ROWS / 8;
  localparam int AddrW      = $clog2(StoreBytes);
  localparam int ShortRows  = MAX_ROWS / 2;
  localparam int LimitFull  = StoreBytes;
  localparam int LimitShort = DISPLAY_WIDTH * ShortRows / 8;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(StoreBytes - 1);

  state_e             state_q, state_d;
  logic               short_panel_q;
  logic [AddrW-1:0]   clr_cnt_q, clr_cnt_d;
  logic               clr_resp_q, clr_resp_d;

  // item registers
  action_e            op_q;
  logic               ok_q;
  logic [2:0]         bit_q;
  logic               on_q;
  logic [AddrW-1:0]   addr_q;

  // store and its ports
  logic [7:0]         mem [StoreBytes];
  logic [7:0]         rdata_q;
  logic               mem_re, mem_we;
  logic [AddrW-1:0]   mem_raddr, mem_waddr;
  logic [7:0]         mem_wdata;

  // output register
  logic               out_valid_q;
  logic               pixel_on_q;
  logic [7:0]         byte_data_q;
  logic               status_q;

  logic               in_accept, out_free, resp_fire;
  action_e            act;
  logic [31:0]        rows, limit, pix_addr, idx_full;
  logic               pix_ok, idx_ok, item_ok, color_on;
  logic [7:0]         mask;

  assign act       = action_e'(action_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign resp_fire = (state_q == S_RESP) && out_free;

  // range checks for the active height
  always_comb begin
    rows     = short_panel_q ? 32'(ShortRows) : 32'(MAX_ROWS);
    limit    = short_panel_q ? 32'(LimitShort) : 32'(LimitFull);
    pix_addr = 32'(y_pos_i[5:3]) * 32'(DISPLAY_WIDTH) + 32'(x_pos_i);
    idx_full = 32'(byte_index_i);
    pix_ok   = (32'(x_pos_i) < 32'(DISPLAY_WIDTH)) && (32'(y_pos_i) < rows) &&
               (pix_addr < 32'(StoreBytes));
    idx_ok   = (idx_full < limit) && (idx_full < 32'(StoreBytes));
    case (act)
      ACT_SET_PIXEL, ACT_GET_PIXEL: item_ok = pix_ok;
      ACT_READ_BYTE:                item_ok = idx_ok;
      ACT_CLEAR_ALL:                item_ok = 1'b1;
      default:                      item_ok = 1'b0;
    endcase
  end

  // faint colors dither off on odd x+y
  assign color_on = (color_i != 24'd0) &&
                    !(((color_i & HighBits) == 24'd0) && (x_pos_i[0] ^ y_pos_i[0]));

  // store read at accept
  assign mem_re    = in_accept && item_ok && (act != ACT_CLEAR_ALL);
  assign mem_raddr = (act == ACT_READ_BYTE) ? idx_full[AddrW-1:0] : pix_addr[AddrW-1:0];

  // store write: clearing sweep or set-pixel write-back
  assign mask = 8'b1 << bit_q;
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = on_q ? (rdata_q | mask) : (rdata_q & ~mask);
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = 8'd0;
    end else if (resp_fire && (op_q == ACT_SET_PIXEL) && ok_q) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // control state machine
  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    clr_resp_d = clr_resp_q;
    case (state_q)
      S_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          clr_cnt_d = '0;
          state_d   = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          if (act == ACT_CLEAR_ALL) begin
            state_d    = S_CLEAR;
            clr_cnt_d  = '0;
            clr_resp_d = 1'b1;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      clr_resp_q    <= 1'b0;
      short_panel_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_cnt_q  <= clr_cnt_d;
      clr_resp_q <= clr_resp_d;
      if (cfg_we_i) begin
        short_panel_q <= cfg_wdata_i;
      end
      if (resp_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture at accept
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= act;
      ok_q   <= item_ok;
      bit_q  <= y_pos_i[2:0];
      on_q   <= color_on;
      addr_q <= pix_addr[AddrW-1:0];
    end
  end

  // result beat
  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      pixel_on_q  <= (op_q == ACT_GET_PIXEL) && ok_q && rdata_q[bit_q];
      byte_data_q <= ((op_q == ACT_READ_BYTE) && ok_q) ? rdata_q : 8'd0;
      status_q    <= !ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_on_o  = pixel_on_q;
  assign byte_data_o = byte_data_q;
  assign status_o    = status_q;

endmodule

/* tb/tb_top.sv */
// self-checking bench for page_mono_framebuffer_core: directed pixel, clear, byte and
// height cases, then randomized beats with idling and back-pressure on both channels
// depends on pmfb_pkg and the core; predicts every result with its own page model
`timescale 1ns / 1ps

module tb_top;
  import pmfb_pkg::*;

  localparam int StoreBytes  = DefDisplayWidth * DefMaxRows / 8;
  localparam int HoldCycles  = 200;
  localparam int CycleLimit  = 500_000;
  localparam int IdlePercent = 33;

  typedef struct packed {
    logic       pixel_on;
    logic [7:0] byte_data;
    logic       status;
  } fb_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  action_i;
  logic [6:0]  x_pos_i;
  logic [5:0]  y_pos_i;
  logic [23:0] color_i;
  logic [9:0]  byte_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        pixel_on_o;
  logic [7:0]  byte_data_o;
  logic        status_o;

  // predictor state: page store and panel height
  logic [7:0]  page_bytes [StoreBytes];
  logic        panel_short;
  fb_result_t  pending_results [$];

  // traffic shaping; quiet, burst and hold_requests are written only by the test sequence
  logic        quiet;
  logic        burst;
  int          hold_requests;
  int          holds_served;

  int          beats_sent;
  int          results_checked;
  int          clears_sent;
  int          mismatches;
  int          cycle_cnt;
  logic [6:0]  last_x;
  logic [5:0]  last_y;

  page_mono_framebuffer_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .x_pos_i      (x_pos_i),
    .y_pos_i      (y_pos_i),
    .color_i      (color_i),
    .byte_index_i (byte_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_on_o   (pixel_on_o),
    .byte_data_o  (byte_data_o),
    .status_o     (status_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             pending_results.size());
    $display("tb_top NOT OK");
    $finish;
  end

  // page model of one accepted beat
  function automatic fb_result_t model_page_beat(action_e act, logic [6:0] x,
                                                 logic [5:0] y, logic [23:0] color,
                                                 logic [9:0] bidx);
    fb_result_t res;
    int         rows;
    int         addr;
    logic       lit;
    res  = '0;
    rows = panel_short ? DefMaxRows / 2 : DefMaxRows;
    addr = (int'(y) / 8) * DefDisplayWidth + int'(x);
    case (act)
      ACT_CLEAR_ALL: begin
        foreach (page_bytes[i]) page_bytes[i] = 8'h00;
      end
      ACT_READ_BYTE: begin
        if (int'(bidx) < DefDisplayWidth * rows / 8) res.byte_data = page_bytes[bidx];
        else res.status = 1'b1;
      end
      default: begin
        if (int'(x) >= DefDisplayWidth || int'(y) >= rows) begin
          res.status = 1'b1;
        end else if (act == ACT_SET_PIXEL) begin
          // faint colors are dithered off where x+y is odd
          lit = (color != 24'h0) && !(((color & HighBits) == 24'h0) && (x[0] ^ y[0]));
          page_bytes[addr][y[2:0]] = lit;
        end else begin
          res.pixel_on = page_bytes[addr][y[2:0]];
        end
      end
    endcase
    return res;
  endfunction

  // send one beat; entered and left at a falling edge, valid stays up for the next beat
  task automatic send_beat(action_e act, logic [6:0] x, logic [5:0] y,
                           logic [23:0] color, logic [9:0] bidx);
    while (!quiet && !burst && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    x_pos_i      <= x;
    y_pos_i      <= y;
    color_i      <= color;
    byte_index_i <= bidx;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(model_page_beat(act, x, y, color, bidx));
    beats_sent++;
    if (act == ACT_CLEAR_ALL) clears_sent++;
    @(negedge clk_i);
  endtask

  // drop valid and wait for every expected result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // panel height write, only with the block idle
  task automatic write_panel(logic short_sel);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= short_sel;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    panel_short = short_sel;
  endtask

  // result checker
  always @(posedge clk_i) begin
    fb_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result pixel_on=%0b byte_data=%02h status=%0b",
                 $time, pixel_on_o, byte_data_o, status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (pixel_on_o !== want.pixel_on) begin
          $display("%0t: pixel_on expected %0b got %0b", $time, want.pixel_on, pixel_on_o);
          mismatches++;
        end
        if (byte_data_o !== want.byte_data) begin
          $display("%0t: byte_data expected %02h got %02h", $time, want.byte_data,
                   byte_data_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0b got %0b", $time, want.status, status_o);
          mismatches++;
        end
      end
    end
  end

  // output stall: random idling, long hold-offs on request
  initial begin
    out_stall_i  = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        holds_served++;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < IdlePercent);
      end
    end
  end

  // set, get, dither, byte reads, short panel bounds, hidden rows, clear
  task automatic test_directed();
    send_beat(ACT_SET_PIXEL, 7'd0, 6'd0, 24'hFFFFFF, 10'd0);
    send_beat(ACT_SET_PIXEL, 7'd127, 6'd63, 24'h800000, 10'd1023);
    send_beat(ACT_GET_PIXEL, 7'd0, 6'd0, 24'h0, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd127, 6'd63, 24'h0, 10'd0);
    send_beat(ACT_SET_PIXEL, 7'd1, 6'd0, 24'h7F7F7F, 10'd0);
    send_beat(ACT_SET_PIXEL, 7'd2, 6'd0, 24'h010101, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd1, 6'd0, 24'h0, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd2, 6'd0, 24'h0, 10'd0);
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd0);
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd1023);
    send_beat(ACT_SET_PIXEL, 7'd0, 6'd0, 24'h000000, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd0, 6'd0, 24'h0, 10'd0);
    write_panel(1'b1);
    send_beat(ACT_SET_PIXEL, 7'd5, 6'd32, 24'hFFFFFF, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd127, 6'd63, 24'h0, 10'd0);
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd512);
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd511);
    send_beat(ACT_SET_PIXEL, 7'd127, 6'd31, 24'h008000, 10'd0);
    send_beat(ACT_GET_PIXEL, 7'd127, 6'd31, 24'h0, 10'd0);
    write_panel(1'b0);
    // hidden rows keep their bits
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd1023);
    send_beat(ACT_GET_PIXEL, 7'd127, 6'd63, 24'h0, 10'd0);
    send_beat(ACT_CLEAR_ALL, 7'd127, 6'd63, 24'hFFFFFF, 10'd1023);
    send_beat(ACT_READ_BYTE, 7'd0, 6'd0, 24'h0, 10'd1023);
    send_beat(ACT_GET_PIXEL, 7'd2, 6'd0, 24'h0, 10'd0);
    drain_results();
  endtask

  // one random beat, biased toward pixels that were written recently
  task automatic send_random_beat();
    int          pick;
    int          rows;
    action_e     act;
    logic [6:0]  x;
    logic [5:0]  y;
    logic [23:0] color;
    logic [9:0]  bidx;
    rows = panel_short ? DefMaxRows / 2 : DefMaxRows;
    pick = $urandom_range(99);
    if (pick < 2) act = ACT_CLEAR_ALL;
    else if (pick < 42) act = ACT_SET_PIXEL;
    else if (pick < 70) act = ACT_GET_PIXEL;
    else act = ACT_READ_BYTE;
    x    = 7'($urandom_range(127));
    y    = ($urandom_range(99) < 85) ? 6'($urandom_range(rows - 1)) : 6'($urandom_range(63));
    bidx = 10'($urandom_range(1023));
    if (act != ACT_SET_PIXEL && $urandom_range(1) == 1) begin
      x    = last_x;
      y    = last_y;
      bidx = 10'((int'(last_y) / 8) * DefDisplayWidth + int'(last_x));
    end else if (act == ACT_READ_BYTE && $urandom_range(99) < 80) begin
      bidx = 10'($urandom_range(DefDisplayWidth * rows / 8 - 1));
    end
    pick = $urandom_range(99);
    if (pick < 25) begin
      color = 24'h0;
    end else if (pick < 55) begin
      color = 24'($urandom) & ~HighBits;
      if (color == 24'h0) color = 24'h000001;
    end else begin
      color = 24'($urandom);
    end
    if (act == ACT_SET_PIXEL) begin
      last_x = x;
      last_y = y;
    end
    send_beat(act, x, y, color, bidx);
  endtask

  // long output hold-off while the sender keeps pushing
  task automatic test_output_holdoff();
    burst = 1'b1;
    hold_requests++;
    repeat (24) send_random_beat();
    burst = 1'b0;
    drain_results();
  endtask

  // sender pauses until every result is back, twice
  task automatic test_sender_pause();
    repeat (2) begin
      repeat (10) send_random_beat();
      drain_results();
    end
  endtask

  // stretch with no idling on either side
  task automatic test_no_idle(int beats);
    quiet = 1'b1;
    repeat (beats) send_random_beat();
    quiet = 1'b0;
  endtask

  // random traffic over alternating panel heights
  task automatic test_random_heights(int beats_per_phase);
    for (int phase = 0; phase < 5; phase++) begin
      write_panel(phase[0]);
      repeat (beats_per_phase) send_random_beat();
    end
    write_panel(1'b0);
  endtask

  // test sequence
  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    in_valid_i      = 1'b0;
    action_i        = ACT_SET_PIXEL;
    x_pos_i         = '0;
    y_pos_i         = '0;
    color_i         = '0;
    byte_index_i    = '0;
    quiet           = 1'b0;
    burst           = 1'b0;
    hold_requests   = 0;
    beats_sent      = 0;
    results_checked = 0;
    clears_sent     = 0;
    mismatches      = 0;
    panel_short     = 1'b0;
    last_x          = '0;
    last_y          = '0;
    foreach (page_bytes[i]) page_bytes[i] = 8'h00;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_output_holdoff();
    test_sender_pause();
    test_no_idle(150);
    test_random_heights(240);

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("%0d beats sent, %0d results checked, %0d clears, both panel heights",
             beats_sent, results_checked, clears_sent);
    $display("idling, long output hold-off and sender drain pauses exercised");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* page_mono_framebuffer_core.f */
design/pmfb_pkg.sv
design/page_mono_framebuffer_core.sv
tb/tb_top.sv
